>>> hw/rtl/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int NumWords  = 44;
  localparam int WordIdxW  = 6;
  localparam logic [7:0] PolyRed = 8'h1b;

  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SUB_TABLE [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic load;
    logic dec;
    logic first;
    logic last;
  } round_ctl_t;

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? PolyRed : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/aes_ram.sv
`default_nettype none
module aes_ram #(
  parameter int Width = 32,
  parameter int Depth = 44
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/aes_round.sv
`default_nettype none
module aes_round (
  input  wire logic                  clk,
  input  wire aes_pkg::round_ctl_t   ctl,
  input  wire logic                  step,
  input  wire logic [127:0]          load_data,
  input  wire logic [127:0]          round_key,
  output logic      [127:0]          state
);
  logic [127:0] state_r;
  logic [127:0] state_nxt;
  logic [7:0]   s   [16];
  logic [7:0]   sr  [16];
  logic [7:0]   sb  [16];
  logic [7:0]   mc  [16];
  logic [7:0]   ak  [16];
  logic [7:0]   o   [16];
  logic [7:0]   a0, a1, a2, a3;
  logic [7:0]   x0, x1, x2, x3;
  logic [7:0]   y0, y1, y2, y3;
  logic [7:0]   z0, z1, z2, z3;

  // Forward round: sub, shift, mix, key. Inverse: shift, sub, key, mix.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i]  = state_r[127-8*i -: 8];
      sr[i] = 8'h00;
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (ctl.dec) begin
          sr[r + 4*((c + r) % 4)] = s[r + 4*c];
        end else begin
          sr[r + 4*c] = aes_pkg::FWD_SBOX[s[r + 4*((c + r) % 4)]];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = ctl.dec ? aes_pkg::INV_SUB_TABLE[sr[i]] : sr[i];
      ak[i] = 8'h00;
      mc[i] = 8'h00;
    end
    for (int c = 0; c < 4; c++) begin
      // Inverse mixes after key addition; forward mixes before.
      for (int r = 0; r < 4; r++) begin
        ak[4*c+r] = ctl.dec ? (sb[4*c+r] ^ round_key[127-8*(4*c+r) -: 8]) : sb[4*c+r];
      end
      a0 = ak[4*c]; a1 = ak[4*c+1]; a2 = ak[4*c+2]; a3 = ak[4*c+3];
      x0 = aes_pkg::xt(a0); x1 = aes_pkg::xt(a1);
      x2 = aes_pkg::xt(a2); x3 = aes_pkg::xt(a3);
      y0 = aes_pkg::xt(x0); y1 = aes_pkg::xt(x1);
      y2 = aes_pkg::xt(x2); y3 = aes_pkg::xt(x3);
      z0 = aes_pkg::xt(y0); z1 = aes_pkg::xt(y1);
      z2 = aes_pkg::xt(y2); z3 = aes_pkg::xt(y3);
      if (ctl.dec) begin
        mc[4*c]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
        mc[4*c+1] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
        mc[4*c+2] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
        mc[4*c+3] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
      end else begin
        mc[4*c]   = x0 ^ (x1^a1) ^ a2 ^ a3;
        mc[4*c+1] = a0 ^ x1 ^ (x2^a2) ^ a3;
        mc[4*c+2] = a0 ^ a1 ^ x2 ^ (x3^a3);
        mc[4*c+3] = (x0^a0) ^ a1 ^ a2 ^ x3;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (ctl.first) begin
        o[i] = s[i] ^ round_key[127-8*i -: 8];
      end else if (ctl.dec) begin
        o[i] = ctl.last ? ak[i] : mc[i];
      end else begin
        o[i] = (ctl.last ? sb[i] : mc[i]) ^ round_key[127-8*i -: 8];
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_nxt[127-8*i -: 8] = o[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      state_r <= load_data;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;
endmodule
`default_nettype wire

>>> hw/rtl/aes128_block_cipher.sv
`default_nettype none
// One block per start transfer; a new start is accepted only once the block
// is back in idle. With the key schedule ready, each of the 11 round steps
// (initial key addition and ten rounds) first fetches its four round-key
// words from the 44-word round-key RAM, one word per cycle behind the
// registered read, and then passes through the single shared round unit;
// ST_DONE registers the result, and out_valid, registered from ST_DONE, is
// high once the block is back in idle, so busy is already low again. The
// first block after a key write first runs the key expansion: it writes the
// four key words and then computes one schedule word per cycle. A start
// request wins over a key write in the same idle cycle. out_valid pulses for
// one cycle and cannot be held off; collect the result in that cycle.
module aes128_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  output logic             out_valid,
  output logic      [63:0] out_result_high,
  output logic      [63:0] out_result_low,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_EXP_RD, ST_EXP, ST_FETCH, ST_ROUND, ST_DONE
  } state_t;

  state_t       state_r;
  logic         keys_ready_r;
  logic [63:0]  key_high_r, key_low_r;
  logic         dec_r;
  logic [127:0] blk_r;
  logic [31:0]  w_r [4];
  logic [5:0]   widx_r;
  logic [7:0]   rc_r;
  logic [3:0]   rnd_r;
  logic [2:0]   fcnt_r;
  logic [127:0] rkey_r;
  logic         out_valid_r;

  logic         ram_we;
  logic [5:0]   ram_waddr, ram_raddr;
  logic [31:0]  ram_wdata, ram_rdata;
  logic [31:0]  tmp, neww;
  logic [3:0]   key_rnd;
  aes_pkg::round_ctl_t ctl;
  logic         step;
  logic [127:0] st;

  assign cfg_ready = (state_r == ST_IDLE) && !start;
  assign busy      = (state_r != ST_IDLE);

  // Expansion keeps the last four words in w_r; word widx_r is produced.
  always_comb begin
    tmp = w_r[3];
    if (widx_r[1:0] == 2'd0) begin
      tmp = aes_pkg::sub_word({w_r[3][23:0], w_r[3][31:24]}) ^ {rc_r, 24'h0};
    end
    neww = w_r[0] ^ tmp;
  end

  assign key_rnd   = dec_r ? 4'(aes_pkg::NumRounds) - rnd_r : rnd_r;
  assign ram_raddr = 6'({key_rnd, 2'b00}) + 6'(fcnt_r[1:0]);
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx_r;
    ram_wdata = neww;
    if (state_r == ST_EXP_RD) begin
      ram_we    = 1'b1;
      ram_waddr = 6'(fcnt_r[1:0]);
      ram_wdata = w_r[fcnt_r[1:0]];
    end else if (state_r == ST_EXP) begin
      ram_we = 1'b1;
    end
  end

  aes_ram #(.Width(32), .Depth(aes_pkg::NumWords)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign ctl.load  = (state_r == ST_IDLE) && start;
  assign ctl.dec   = ctl.load ? in_req_type : dec_r;
  assign ctl.first = (rnd_r == 4'd0);
  assign ctl.last  = (rnd_r == 4'(aes_pkg::NumRounds));
  assign step      = (state_r == ST_ROUND);

  aes_round u_round (
    .clk(clk), .ctl(ctl), .step(step),
    .load_data({in_block_high, in_block_low}), .round_key(rkey_r), .state(st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keys_ready_r <= 1'b0;
      key_high_r   <= '0;
      key_low_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_DONE);
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            dec_r  <= in_req_type;
            rnd_r  <= 4'd0;
            fcnt_r <= 3'd0;
            if (keys_ready_r) begin
              state_r <= ST_FETCH;
            end else begin
              w_r[0] <= key_high_r[63:32];
              w_r[1] <= key_high_r[31:0];
              w_r[2] <= key_low_r[63:32];
              w_r[3] <= key_low_r[31:0];
              rc_r   <= 8'h01;
              widx_r <= 6'd4;
              state_r <= ST_EXP_RD;
            end
          end else if (cfg_valid) begin
            keys_ready_r <= 1'b0;
            if (cfg_index == aes_pkg::CfgKeyHigh) begin
              key_high_r <= cfg_data;
            end else begin
              key_low_r <= cfg_data;
            end
          end
        end
        ST_EXP_RD: begin
          // Writes the four key words into the RAM.
          if (fcnt_r == 3'd3) begin
            fcnt_r  <= 3'd0;
            state_r <= ST_EXP;
          end else begin
            fcnt_r <= fcnt_r + 3'd1;
          end
        end
        ST_EXP: begin
          w_r[0] <= w_r[1];
          w_r[1] <= w_r[2];
          w_r[2] <= w_r[3];
          w_r[3] <= neww;
          if (widx_r[1:0] == 2'd0) begin
            rc_r <= aes_pkg::xt(rc_r);
          end
          widx_r <= widx_r + 6'd1;
          if (widx_r == 6'(aes_pkg::NumWords - 1)) begin
            keys_ready_r <= 1'b1;
            state_r      <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          // RAM read data is registered and appears in the cycle after its address.
          if (fcnt_r != 3'd0) begin
            rkey_r <= {rkey_r[95:0], ram_rdata};
          end
          if (fcnt_r == 3'd4) begin
            fcnt_r  <= 3'd0;
            state_r <= ST_ROUND;
          end else begin
            fcnt_r <= fcnt_r + 3'd1;
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 4'd1;
          if (ctl.last) begin
            state_r     <= ST_DONE;
          end else begin
            state_r <= ST_FETCH;
          end
        end
        ST_DONE: begin
          blk_r       <= st;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = blk_r[127:64];
  assign out_result_low  = blk_r[63:0];

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy) else $error("cfg accepted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_round_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> keys_ready_r) else $error("round without keys");
endmodule
`default_nettype wire

>>> sim/aes128_block_cipher_test.sv
`timescale 1ns / 1ps
module aes128_block_cipher_test;

  typedef struct packed {
    logic        dec;
    logic [63:0] hi;
    logic [63:0] lo;
  } block_req_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_res_t;

  typedef struct packed {
    logic        idx;
    logic [63:0] data;
  } key_write_t;

  localparam int StallLimit = 20000;
  localparam int TailCycles = 300;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [63:0] in_block_high;
  logic [63:0] in_block_low;
  logic        out_valid;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  aes128_block_cipher u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_block_high(in_block_high),
    .in_block_low(in_block_low), .out_valid(out_valid),
    .out_result_high(out_result_high), .out_result_low(out_result_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  block_req_t  pending_blocks[$];
  block_res_t  expected_blocks[$];
  key_write_t  pending_keys[$];
  int          errors;
  int          idle_cycles;
  int          gap_left;
  bit          hold_sender;

  // Model state: key registers and the expanded schedule.
  logic [63:0] key_hi_m;
  logic [63:0] key_lo_m;
  logic [31:0] sched[44];
  bit          sched_valid;
  logic [7:0]  inv_box[256];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] xtime8(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) p ^= a;
      a = xtime8(a);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {aes_pkg::FWD_SBOX[w[31:24]], aes_pkg::FWD_SBOX[w[23:16]],
            aes_pkg::FWD_SBOX[w[15:8]], aes_pkg::FWD_SBOX[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    logic [7:0]  rc;
    logic [31:0] t;
    rc = 8'h01;
    sched[0] = key_hi_m[63:32];
    sched[1] = key_hi_m[31:0];
    sched[2] = key_lo_m[63:32];
    sched[3] = key_lo_m[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xtime8(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
    sched_valid = 1'b1;
  endfunction

  function automatic block_res_t cipher_block(input block_req_t rq);
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] a[4];
    logic [7:0] m[4];
    block_res_t res;
    int rd;
    if (!sched_valid) expand_schedule();
    for (int i = 0; i < 8; i++) begin
      s[i]   = rq.hi[63-8*i -: 8];
      s[8+i] = rq.lo[63-8*i -: 8];
    end
    if (rq.dec) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int step = 0; step <= 10; step++) begin
      rd = rq.dec ? 10 - step : step;
      if (step > 0) begin
        // Byte substitution and row rotation commute, so order is free here.
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) begin
            if (rq.dec) t[r + 4*((c+r)%4)] = inv_box[s[r + 4*c]];
            else t[r + 4*c] = aes_pkg::FWD_SBOX[s[r + 4*((c+r)%4)]];
          end
        s = t;
        if (!rq.dec && step < 10) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
            for (int r = 0; r < 4; r++) begin
              s[4*c+r] = 8'h00;
              for (int k = 0; k < 4; k++) s[4*c+r] ^= gf_mul(m[(k+4-r)%4], a[k]);
            end
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[4*c+r] ^= sched[4*rd+c][31-8*r -: 8];
      if (rq.dec && step > 0 && step < 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
          for (int r = 0; r < 4; r++) begin
            s[4*c+r] = 8'h00;
            for (int k = 0; k < 4; k++) s[4*c+r] ^= gf_mul(m[(k+4-r)%4], a[k]);
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[8+i];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edge_word(input int k);
    case (k % 5)
      0: return 64'h0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h0000_0000_0000_0001;
      default: return rand64();
    endcase
  endfunction

  // Driver: blocks go out with random gaps; a start stays high until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      if (pending_blocks.size() > 0 && !hold_sender && $urandom_range(0, 2) == 0) begin
        in_req_type   <= pending_blocks[0].dec;
        in_block_high <= pending_blocks[0].hi;
        in_block_low  <= pending_blocks[0].lo;
        expected_blocks.push_back(cipher_block(pending_blocks.pop_front()));
      end else begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_blocks.size() > 0 && !hold_sender) begin
        start         <= 1'b1;
        in_req_type   <= pending_blocks[0].dec;
        in_block_high <= pending_blocks[0].hi;
        in_block_low  <= pending_blocks[0].lo;
        expected_blocks.push_back(cipher_block(pending_blocks.pop_front()));
      end
    end
  end

  // Key writes are issued only by the sequence below while the block is idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == aes_pkg::CfgKeyHigh) key_hi_m = cfg_data;
      else key_lo_m = cfg_data;
      sched_valid = 1'b0;
      void'(pending_keys.pop_front());
      if (pending_keys.size() > 0) begin
        cfg_index <= pending_keys[0].idx;
        cfg_data  <= pending_keys[0].data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end else if (!cfg_valid && pending_keys.size() > 0) begin
      cfg_valid <= 1'b1;
      cfg_index <= pending_keys[0].idx;
      cfg_data  <= pending_keys[0].data;
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    block_res_t exp_res;
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected result %h %h", out_result_high, out_result_low);
          errors++;
        end else begin
          exp_res = expected_blocks.pop_front();
          if (out_result_high !== exp_res.hi) begin
            $error("result_high expected %h actual %h", exp_res.hi, out_result_high);
            errors++;
          end
          if (out_result_low !== exp_res.lo) begin
            $error("result_low expected %h actual %h", exp_res.lo, out_result_low);
            errors++;
          end
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_blocks.size() > 0 || start || expected_blocks.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] khi, input logic [63:0] klo);
    wait_drained();
    pending_keys.push_back('{idx: aes_pkg::CfgKeyHigh, data: khi});
    pending_keys.push_back('{idx: aes_pkg::CfgKeyLow, data: klo});
    while (pending_keys.size() > 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    block_req_t rq;
    for (int i = 0; i < count; i++) begin
      rq.dec = $urandom_range(0, 1);
      rq.hi = rand64();
      rq.lo = rand64();
      pending_blocks.push_back(rq);
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_sender = 1'b0;
    key_hi_m = '0;
    key_lo_m = '0;
    sched_valid = 1'b0;
    for (int i = 0; i < 256; i++) inv_box[aes_pkg::FWD_SBOX[i]] = i[7:0];
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = 1'b0;
    in_block_high = '0;
    in_block_low = '0;
    cfg_valid = 1'b0;
    cfg_index = aes_pkg::CfgKeyHigh;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Blocks before any key write use the all-zero key.
    pending_blocks.push_back('{dec: 1'b0, hi: 64'h0, lo: 64'h0});
    pending_blocks.push_back('{dec: 1'b1, hi: '1, lo: '1});
    set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    pending_blocks.push_back('{dec: 1'b0, hi: 64'h3243f6a8885a308d, lo: 64'h313198a2e0370734});
    pending_blocks.push_back('{dec: 1'b1, hi: 64'h3925841d02dc09fb, lo: 64'hdc118597196a0b32});
    for (int k = 0; k < 10; k++)
      pending_blocks.push_back('{dec: k[0], hi: edge_word(k), lo: edge_word(k + 2)});
    set_key('1, '1);
    queue_random(6);
    // Only one key half written: the schedule must still be rebuilt.
    wait_drained();
    pending_keys.push_back('{idx: aes_pkg::CfgKeyLow, data: 64'h0});
    while (pending_keys.size() > 0) @(posedge clk);
    queue_random(4);

    // Sender holds off until every expected result has come back.
    hold_sender = 1'b1;
    while (start || expected_blocks.size() > 0) @(posedge clk);
    hold_sender = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      set_key(ph == 0 ? 64'h0 : rand64(), ph == 7 ? '1 : rand64());
      queue_random(48);
    end
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
